>>> rtl/trp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transfer rate pacer.
// Used by trp_front, trp_queue, trp_back and transfer_rate_pacer; no dependencies.
package trp_pkg;

	localparam int TIME_W  = 48;
	localparam int BYTES_W = 40;
	localparam int CHUNK_W = 21;
	localparam int RATE_W  = 20;
	localparam int PROD_W  = BYTES_W + RATE_W;   // bytes times one million
	localparam int KIB_SH  = 10;                 // divide by 1024
	localparam int QUO_W   = PROD_W - KIB_SH;    // scaled numerator and quotient
	localparam int CNT_W   = 6;
	localparam int IDX_W   = 2;
	localparam int QDEPTH  = 2;

	localparam logic [CHUNK_W-1:0] MAX_CHUNK_BYTES = 21'd1048576;
	localparam logic [RATE_W-1:0]  US_PER_SEC      = 20'd1000000;
	localparam logic [16:0]        SLACK_US        = 17'd100000;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FAST_RATE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SLOW_RATE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_START_SLOW = 2'd2;

	typedef enum logic {
		KIND_CHUNK,
		KIND_MODE
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic                want_slow;
		logic [CHUNK_W-1:0]  bytes;     // already clamped to the chunk limit
		logic [TIME_W-1:0]   now_us;
	} item_t;

	typedef struct packed {
		logic [RATE_W-1:0] fast_rate_kb;
		logic [RATE_W-1:0] slow_rate_kb;
		logic              start_wr;
		logic              start_val;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_CMP,
		S_DONE
	} back_state_t;

endpackage

>>> rtl/trp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and clamps the chunk size.
// Depends on trp_pkg.
module trp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [trp_pkg::CHUNK_W-1:0]   chunk_bytes,
	input  logic [trp_pkg::TIME_W-1:0]    now_us,
	input  logic                          want_slow,
	output logic                          push_valid,
	input  logic                          push_ready,
	output trp_pkg::item_t                push_item
);

	logic           valid_s1;
	trp_pkg::item_t item_s1;
	trp_pkg::item_t item_d;

	// classify the beat and clamp oversized chunks
	always_comb begin
		item_d.kind      = mode ? trp_pkg::KIND_MODE : trp_pkg::KIND_CHUNK;
		item_d.want_slow = want_slow;
		item_d.bytes     = (chunk_bytes > trp_pkg::MAX_CHUNK_BYTES) ?
		                   trp_pkg::MAX_CHUNK_BYTES : chunk_bytes;
		item_d.now_us    = now_us;
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// hold the classified beat until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

>>> rtl/trp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the pacing engine.
// Depends on trp_pkg.
module trp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  trp_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output trp_pkg::item_t pop_item
);

	trp_pkg::item_t entry_q [trp_pkg::QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'(trp_pkg::QDEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/trp_back.sv
`timescale 1ns / 1ps
// Pacing engine: holds mode, mark and byte total, divides serially, drives results.
// Depends on trp_pkg.
module trp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trp_pkg::cfg_t                 cfg,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  trp_pkg::item_t                pop_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [trp_pkg::TIME_W-1:0]    wait_us,
	output logic                          blocked,
	output logic                          slow_now
);

	trp_pkg::back_state_t state_q, state_d;

	// pacing state
	logic                          slow_q;
	logic                          mark_valid_q;
	logic [trp_pkg::TIME_W-1:0]    mark_q;
	logic [trp_pkg::BYTES_W-1:0]   bytes_q;

	// per-item working registers
	logic [trp_pkg::TIME_W-1:0]    now_q;
	logic [trp_pkg::TIME_W-1:0]    elapsed_q;
	logic [trp_pkg::RATE_W-1:0]    rate_q;
	logic [trp_pkg::QUO_W-1:0]     num_q;
	logic [trp_pkg::RATE_W-1:0]    rem_q;
	logic [trp_pkg::CNT_W-1:0]     cnt_q;
	logic [trp_pkg::TIME_W-1:0]    res_wait_q;
	logic                          res_blocked_q;

	// output register
	logic                          out_valid_q;
	logic [trp_pkg::TIME_W-1:0]    wait_q;
	logic                          blocked_q;
	logic                          slow_now_q;

	logic [trp_pkg::TIME_W-1:0]    mark_eff;
	logic [trp_pkg::RATE_W-1:0]    rate_sel;
	logic                          is_blocked;
	logic                          is_free;
	logic [trp_pkg::BYTES_W:0]     bytes_sum;
	logic [trp_pkg::BYTES_W-1:0]   bytes_new;
	logic [trp_pkg::PROD_W-1:0]    prod;
	logic [trp_pkg::RATE_W:0]      rem_sh;
	logic [trp_pkg::RATE_W:0]      rem_diff;
	logic                          rem_ge;
	logic [trp_pkg::QUO_W-1:0]     elapsed_ext;
	logic [trp_pkg::QUO_W-1:0]     thresh;
	logic [trp_pkg::QUO_W-1:0]     wait_full;
	logic                          slot_free;

	// classify against current state
	assign mark_eff   = mark_valid_q ? mark_q : pop_item.now_us;
	assign rate_sel   = slow_q ? cfg.slow_rate_kb : cfg.fast_rate_kb;
	assign is_blocked = slow_q && (rate_sel == '0);
	assign is_free    = (rate_sel == '0);
	assign bytes_sum  = {1'b0, bytes_q} + (trp_pkg::BYTES_W + 1)'(pop_item.bytes);
	assign bytes_new  = bytes_sum[trp_pkg::BYTES_W] ? '1 : bytes_sum[trp_pkg::BYTES_W-1:0];

	// bytes times one million, then scaled down by 1024
	assign prod = trp_pkg::PROD_W'(bytes_q) * trp_pkg::PROD_W'(trp_pkg::US_PER_SEC);

	// one restoring divide step per cycle
	assign rem_sh   = {rem_q, num_q[trp_pkg::QUO_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, rate_q};
	assign rem_diff = rem_sh - {1'b0, rate_q};

	// compare minimum time against elapsed time plus slack
	assign elapsed_ext = trp_pkg::QUO_W'(elapsed_q);
	assign thresh      = trp_pkg::QUO_W'(trp_pkg::SLACK_US) + elapsed_ext;
	assign wait_full   = num_q - elapsed_ext;

	assign slot_free = !out_valid_q || out_ready;
	assign pop_ready = (state_q == trp_pkg::S_IDLE);

	assign out_valid = out_valid_q;
	assign wait_us   = wait_q;
	assign blocked   = blocked_q;
	assign slow_now  = slow_now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			trp_pkg::S_IDLE: begin
				if (pop_valid) begin
					if (pop_item.kind == trp_pkg::KIND_MODE || is_free) begin
						state_d = trp_pkg::S_DONE;
					end else begin
						state_d = trp_pkg::S_MUL;
					end
				end
			end
			trp_pkg::S_MUL: begin
				state_d = trp_pkg::S_DIV;
			end
			trp_pkg::S_DIV: begin
				if (cnt_q == '0) begin
					state_d = trp_pkg::S_CMP;
				end
			end
			trp_pkg::S_CMP: begin
				state_d = trp_pkg::S_DONE;
			end
			trp_pkg::S_DONE: begin
				if (slot_free) begin
					state_d = trp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = trp_pkg::S_IDLE;
			end
		endcase
	end

	// pacing state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q       <= 1'b0;
			mark_valid_q <= 1'b0;
			mark_q       <= '0;
			bytes_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.start_wr && !mark_valid_q) begin
				slow_q <= cfg.start_val;
			end
			case (state_q)
				trp_pkg::S_IDLE: begin
					if (pop_valid) begin
						if (!mark_valid_q) begin
							mark_valid_q <= 1'b1;
							mark_q       <= pop_item.now_us;
						end
						if (pop_item.kind == trp_pkg::KIND_MODE) begin
							if (pop_item.want_slow != slow_q) begin
								slow_q  <= pop_item.want_slow;
								mark_q  <= pop_item.now_us;
								bytes_q <= '0;
							end
						end else if (!is_free) begin
							bytes_q <= bytes_new;
						end
					end
				end
				trp_pkg::S_CMP: begin
					if (num_q > thresh || elapsed_ext > num_q) begin
						mark_q  <= now_q;
						bytes_q <= '0;
					end
				end
				trp_pkg::S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			trp_pkg::S_IDLE: begin
				res_wait_q    <= '0;
				res_blocked_q <= 1'b0;
				now_q         <= pop_item.now_us;
				rate_q        <= rate_sel;
				elapsed_q     <= (pop_item.now_us >= mark_eff) ?
				                 pop_item.now_us - mark_eff : '0;
				if (pop_item.kind == trp_pkg::KIND_CHUNK && is_blocked) begin
					res_blocked_q <= 1'b1;
				end
			end
			trp_pkg::S_MUL: begin
				num_q <= prod[trp_pkg::PROD_W-1:trp_pkg::KIB_SH];
				rem_q <= '0;
				cnt_q <= trp_pkg::CNT_W'(trp_pkg::QUO_W - 1);
			end
			trp_pkg::S_DIV: begin
				rem_q <= rem_ge ? rem_diff[trp_pkg::RATE_W-1:0] : rem_sh[trp_pkg::RATE_W-1:0];
				num_q <= {num_q[trp_pkg::QUO_W-2:0], rem_ge};
				cnt_q <= cnt_q - trp_pkg::CNT_W'(1);
			end
			trp_pkg::S_CMP: begin
				if (num_q > thresh) begin
					res_wait_q <= (wait_full[trp_pkg::QUO_W-1:trp_pkg::TIME_W] != '0) ?
					              '1 : wait_full[trp_pkg::TIME_W-1:0];
				end
			end
			trp_pkg::S_DONE: begin
				if (slot_free) begin
					wait_q     <= res_wait_q;
					blocked_q  <= res_blocked_q;
					slow_now_q <= slow_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/transfer_rate_pacer.sv
`timescale 1ns / 1ps
// Transfer rate pacer top level: configuration registers and the three stages.
// Depends on trp_pkg, trp_front, trp_queue and trp_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: a chunk
//   (mode = 0) with its byte count and timestamp, or a mode change request
//   (mode = 1) with want_slow. Each event yields exactly one result beat on
//   the output channel (out_valid/out_ready): wait_us, blocked, slow_now.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes
//   fast_rate_kb (index 0), slow_rate_kb (index 1) and start_slow (index 2);
//   other indexes are dropped. Write configuration only while idle.
// Processing:
//   Each input beat passes the front register and the queue. Mode events,
//   blocked chunks and chunks in an unlimited mode go from idle straight
//   to the result state. A limited chunk runs a 50-step restoring divide,
//   one quotient bit per cycle, through the multiply, divide, compare and
//   result states. The engine takes no new event until it is back in idle.
// Reset clears the pacing state: fast mode (unless start_slow is written
//   before the first event), zero byte total, mark taken from the first event.
// A stalled receiver holds the result register; the two-entry queue and the
//   front register keep taking input beats until they fill.
module transfer_rate_pacer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [trp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [trp_pkg::RATE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [trp_pkg::CHUNK_W-1:0]   chunk_bytes,
	input  logic [trp_pkg::TIME_W-1:0]    now_us,
	input  logic                          want_slow,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [trp_pkg::TIME_W-1:0]    wait_us,
	output logic                          blocked,
	output logic                          slow_now
);

	logic [trp_pkg::RATE_W-1:0] fast_rate_q;
	logic [trp_pkg::RATE_W-1:0] slow_rate_q;
	logic                       cfg_wr;
	trp_pkg::cfg_t              cfg;

	logic           push_valid;
	logic           push_ready;
	trp_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	trp_pkg::item_t pop_item;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// hold the rate registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_rate_q <= '0;
			slow_rate_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == trp_pkg::REG_FAST_RATE) begin
				fast_rate_q <= cfg_data;
			end
			if (cfg_index == trp_pkg::REG_SLOW_RATE) begin
				slow_rate_q <= cfg_data;
			end
		end
	end

	always_comb begin
		cfg.fast_rate_kb = fast_rate_q;
		cfg.slow_rate_kb = slow_rate_q;
		cfg.start_wr     = cfg_wr && (cfg_index == trp_pkg::REG_START_SLOW);
		cfg.start_val    = cfg_data[0];
	end

	trp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.chunk_bytes (chunk_bytes),
		.now_us      (now_us),
		.want_slow   (want_slow),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	trp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	trp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.wait_us   (wait_us),
		.blocked   (blocked),
		.slow_now  (slow_now)
	);

endmodule
